// ===== hdl/mf3_pkg.sv =====
package mf3_pkg;

  localparam int PIX_W = 8;
  localparam int POS_W = 11;
  localparam int CFG_W = 12;
  localparam int WIN_N = 9;
  localparam int DIM_MIN = 3;
  localparam int WIDTH_RESET = 640;
  localparam int HEIGHT_RESET = 480;
  localparam int MED_STEPS = 19;

  localparam logic [3:0] MED_IDX = 4'd4;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // Compare-exchange network for the median of nine: min goes to LO, max to HI
  localparam logic [3:0] MED_LO [MED_STEPS] = '{
    4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
    4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
  };
  localparam logic [3:0] MED_HI [MED_STEPS] = '{
    4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
    4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
  };

endpackage

// ===== hdl/mf3_ram.sv =====
module mf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mf3_median.sv =====
module mf3_median (
  input  mf3_pkg::win_t win_i,
  output mf3_pkg::pix_t median_o
);

  mf3_pkg::win_t p;
  mf3_pkg::pix_t lo;
  mf3_pkg::pix_t hi;

  always_comb begin
    p = win_i;
    lo = '0;
    hi = '0;
    for (int k = 0; k < mf3_pkg::MED_STEPS; k++) begin
      lo = p[mf3_pkg::MED_LO[k]];
      hi = p[mf3_pkg::MED_HI[k]];
      if (lo > hi) begin
        p[mf3_pkg::MED_LO[k]] = hi;
        p[mf3_pkg::MED_HI[k]] = lo;
      end
    end
  end

  assign median_o = p[mf3_pkg::MED_IDX];

endmodule

// ===== hdl/median_filter_3x3.sv =====
// Channel     Direction  Payload (lowest bit first)
// s_axis      in         tdata: pixel_value[7:0]; tuser: frame_start
// m_axis      out        tdata: median_value[7:0], out_row[18:8], out_col[29:19];
//                        tlast: frame_last
// cfg         in         index 0 frame_width, 1 frame_height; data 12 bits
//
// One pixel is taken every cycle unless back-pressure stalls it; a result passes the
// line-store read issued at accept, the register before the median network and the
// output register. Stages advance independently, so bubbles close up under stall.
// Reset clears counters, window and valid flags; geometry returns to 640 x 480.
// Line stores are not cleared; the configuration port is always ready.
module median_filter_3x3 #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // pixel_value
  input  logic [0:0]                  s_axis_tuser,  // frame_start
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,  // median_value, out_row, out_col
  output logic                        m_axis_tlast,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [0:0]                  cfg_index_i,
  input  logic [mf3_pkg::CFG_W-1:0]   cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = CW + 1;
  localparam int HW = RW + 1;
  localparam int W_RST = (mf3_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                             : mf3_pkg::WIDTH_RESET;
  localparam int H_RST = (mf3_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                               : mf3_pkg::HEIGHT_RESET;

  // Geometry, held clamped
  logic [WW-1:0] width_q, width_d;
  logic [HW-1:0] height_q, height_d;
  logic          cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_fire) begin
      unique case (mf3_pkg::cfg_reg_e'(cfg_index_i))
        mf3_pkg::CFG_FRAME_WIDTH: begin
          if (cfg_data_i < mf3_pkg::CFG_W'(mf3_pkg::DIM_MIN)) begin
            width_d = WW'(mf3_pkg::DIM_MIN);
          end else if (32'(cfg_data_i) > 32'(MAX_WIDTH)) begin
            width_d = WW'(MAX_WIDTH);
          end else begin
            width_d = WW'(cfg_data_i);
          end
        end
        mf3_pkg::CFG_FRAME_HEIGHT: begin
          if (cfg_data_i < mf3_pkg::CFG_W'(mf3_pkg::DIM_MIN)) begin
            height_d = HW'(mf3_pkg::DIM_MIN);
          end else if (32'(cfg_data_i) > 32'(MAX_HEIGHT)) begin
            height_d = HW'(MAX_HEIGHT);
          end else begin
            height_d = HW'(cfg_data_i);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Pipeline control
  logic s_fire, b_go, c_en, o_en;
  logic b_valid_q, c_valid_q, o_valid_q;

  assign o_en          = !o_valid_q || m_axis_tready;
  assign c_en          = !c_valid_q || o_en;
  assign b_go          = b_valid_q && c_en;
  assign s_axis_tready = !b_valid_q || c_en;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // Position of the arriving pixel
  logic [CW-1:0] col_q, col_d, col0, col_a;
  logic [RW-1:0] row_q, row_d, row0, row_a;
  logic [HW-1:0] row1;
  logic [WW-1:0] col_n;
  logic [HW-1:0] row_n;
  logic          emit_a, last_a;

  always_comb begin
    col0 = s_axis_tuser[0] ? '0 : col_q;
    row0 = s_axis_tuser[0] ? '0 : row_q;
    if ({1'b0, col0} >= width_q) begin
      col_a = '0;
      row1  = {1'b0, row0} + HW'(1);
    end else begin
      col_a = col0;
      row1  = {1'b0, row0};
    end
    row_a = (row1 >= height_q) ? '0 : row1[RW-1:0];

    col_n = {1'b0, col_a} + WW'(1);
    row_n = {1'b0, row_a} + HW'(1);
    if (col_n >= width_q) begin
      col_d = '0;
      row_d = (row_n >= height_q) ? '0 : row_n[RW-1:0];
    end else begin
      col_d = col_n[CW-1:0];
      row_d = row_a;
    end

    emit_a = ({1'b0, row_a} >= HW'(2)) && ({1'b0, col_a} >= WW'(2));
    last_a = ({1'b0, row_a} == height_q - HW'(1)) && ({1'b0, col_a} == width_q - WW'(1));
  end

  // Stage B: line-store read data arrives
  mf3_pkg::pix_t b_px_q;
  logic [CW-1:0] b_col_q;
  logic [RW-1:0] b_row_q;
  logic          b_emit_q, b_last_q;
  mf3_pkg::pix_t up_rd, mid_rd, up_eff, mid_eff;
  logic          fwd_q, fwd_d;
  mf3_pkg::pix_t fwd_up_q, fwd_mid_q;

  // Same column written by the departing pixel at the read edge: forward it
  assign fwd_d   = b_go && (b_col_q == col_a);
  assign up_eff  = fwd_q ? fwd_up_q : up_rd;
  assign mid_eff = fwd_q ? fwd_mid_q : mid_rd;

  mf3_ram #(
    .WIDTH (mf3_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_upper (
    .clk_i   (clk_i),
    .we_i    (b_go),
    .waddr_i (b_col_q),
    .wdata_i (mid_eff),
    .re_i    (s_fire),
    .raddr_i (col_a),
    .rdata_o (up_rd)
  );

  mf3_ram #(
    .WIDTH (mf3_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_middle (
    .clk_i   (clk_i),
    .we_i    (b_go),
    .waddr_i (b_col_q),
    .wdata_i (b_px_q),
    .re_i    (s_fire),
    .raddr_i (col_a),
    .rdata_o (mid_rd)
  );

  // Stage C: window and centre position
  mf3_pkg::win_t window_q;
  logic [mf3_pkg::POS_W-1:0] c_row_q, c_col_q;
  logic                      c_last_q;
  logic [RW-1:0]             row_m1;
  logic [CW-1:0]             col_m1;
  mf3_pkg::pix_t             median;

  assign row_m1 = b_row_q - RW'(1);
  assign col_m1 = b_col_q - CW'(1);

  mf3_median u_median (
    .win_i    (window_q),
    .median_o (median)
  );

  // Output register
  mf3_pkg::pix_t             o_median_q;
  logic [mf3_pkg::POS_W-1:0] o_row_q, o_col_q;
  logic                      o_last_q;

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {2'b00, o_col_q, o_row_q, o_median_q};
  assign m_axis_tlast  = o_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WW'(W_RST);
      height_q  <= HW'(H_RST);
      col_q     <= '0;
      row_q     <= '0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
      window_q  <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      if (s_fire) begin
        col_q <= col_d;
        row_q <= row_d;
        fwd_q <= fwd_d;
      end
      if (s_axis_tready) begin
        b_valid_q <= s_fire;
      end
      if (c_en) begin
        c_valid_q <= b_valid_q && b_emit_q;
      end
      if (o_en) begin
        o_valid_q <= c_valid_q;
      end
      if (b_go) begin
        window_q[0] <= window_q[1];
        window_q[1] <= window_q[2];
        window_q[2] <= up_eff;
        window_q[3] <= window_q[4];
        window_q[4] <= window_q[5];
        window_q[5] <= mid_eff;
        window_q[6] <= window_q[7];
        window_q[7] <= window_q[8];
        window_q[8] <= b_px_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      b_px_q    <= s_axis_tdata;
      b_col_q   <= col_a;
      b_row_q   <= row_a;
      b_emit_q  <= emit_a;
      b_last_q  <= last_a;
      fwd_up_q  <= mid_eff;
      fwd_mid_q <= b_px_q;
    end
    if (b_go) begin
      c_row_q  <= mf3_pkg::POS_W'(row_m1);
      c_col_q  <= mf3_pkg::POS_W'(col_m1);
      c_last_q <= b_last_q;
    end
    if (o_en && c_valid_q) begin
      o_median_q <= median;
      o_row_q    <= c_row_q;
      o_col_q    <= c_col_q;
      o_last_q   <= c_last_q;
    end
  end

`ifndef ASSERT_OFF
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !cfg_fire |=> ({1'b0, col_q} < width_q))
    else $error("column counter beyond frame width");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_go && b_last_q |-> b_emit_q)
    else $error("frame end flagged on a border pixel");

  a_no_border_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q |-> (o_row_q != '0) && (o_col_q != '0))
    else $error("border position reached the output");
`endif

endmodule
